[src/swrms_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrms_pkg
// Shared types, widths and codes for the three-channel sliding-window RMS.
// ----------------------------------------------------------------------------
package swrms_pkg;

    // Store and channel geometry
    localparam int WINDOW_DEPTH = 256;
    localparam int SAMPLE_BITS  = 16;
    localparam int CHANNELS     = 3;

    localparam int POS_W   = $clog2(WINDOW_DEPTH);
    localparam int SQ_W    = 2 * SAMPLE_BITS - 1;
    localparam int SUM_W   = SQ_W + POS_W;
    localparam int ROOT_W  = (SUM_W + 1) / 2;
    localparam int WORK_W  = 2 * ROOT_W;
    localparam int REM_W   = ROOT_W + 3;
    localparam int STEP_W  = $clog2(SUM_W + 1);
    localparam int MAG_W   = SAMPLE_BITS + 1;
    localparam int ROW_W   = CHANNELS * SQ_W;

    // Fixed field widths
    localparam int CH_W       = 2;
    localparam int RMS_W      = 16;
    localparam int LEN_W      = 9;
    localparam int WARM_W     = 10;
    localparam int COUNT_W    = 11;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    // Request codes
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_CLEAR  = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP_EXTRA  = 1'b1;

    typedef struct packed {
        logic                          req_type;
        logic [CH_W-1:0]               channel;
        logic signed [SAMPLE_BITS-1:0] sample;
    } in_t;

    typedef struct packed {
        logic [RMS_W-1:0] rms_value;
        logic [CH_W-1:0]  channel_out;
    } out_t;

    // Classified work for the back end
    typedef struct packed {
        logic            is_clear;
        logic [CH_W-1:0] ch;
        logic [SQ_W-1:0] sq;
    } cmd_t;

    // Effective configuration (window length already limited)
    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [WARM_W-1:0] warmup;
    } cfg_t;

    typedef struct packed {
        logic booting;
    } back_status_t;

endpackage

[src/swrms_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrms_fifo
// Short command queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module swrms_fifo
    import swrms_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t wdata,
    output logic full,
    input  logic pop,
    output cmd_t head,
    output logic empty
);

    cmd_t               store [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == Q_CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = store[rd_ptr_reg];

    // Pointer and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[src/swrms_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrms_front
// Accepts input transactions, classifies them and squares the sample.
// ----------------------------------------------------------------------------
module swrms_front
    import swrms_pkg::*;
(
    input  in_t          item,
    input  logic         push,
    output logic         full,
    input  back_status_t status,
    input  logic         q_full,
    output logic         q_push,
    output cmd_t         q_cmd
);

    logic [MAG_W-1:0]   mag;
    logic [2*MAG_W-1:0] sq_full;

    // Hold off while the queue is full or the store is still being cleared after reset
    assign full   = q_full | status.booting;
    assign q_push = push & ~full;

    // Magnitude of the two's complement sample; most negative maps to 2^(N-1)
    always_comb
    begin
        if (item.sample[SAMPLE_BITS-1])
        begin
            mag = {1'b0, ~item.sample} + MAG_W'(1);
        end
        else
        begin
            mag = {1'b0, item.sample};
        end
    end

    assign sq_full = mag * mag;

    // Classified command; out-of-range channels fold onto the last one
    always_comb
    begin
        q_cmd.is_clear = (item.req_type == REQ_CLEAR);
        q_cmd.sq       = sq_full[SQ_W-1:0];
        if (int'(item.channel) >= CHANNELS)
        begin
            q_cmd.ch = CH_W'(CHANNELS - 1);
        end
        else
        begin
            q_cmd.ch = item.channel;
        end
    end

endmodule

[src/swrms_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrms_back
// Window store update, serial divide by window length, serial square root.
// ----------------------------------------------------------------------------
module swrms_back
    import swrms_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    input  cmd_t         q_head,
    input  logic         q_empty,
    output logic         q_pop,
    output back_status_t status,
    input  logic         pop,
    output logic         empty,
    output out_t         result
);

    localparam logic [2:0] ST_INIT = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_READ = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_SQRT = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    // Window store: one row holds the square of every channel at a position
    logic [ROW_W-1:0] mem [WINDOW_DEPTH];
    logic [ROW_W-1:0] row_reg;
    logic             mem_we;
    logic [POS_W-1:0] mem_waddr;
    logic [ROW_W-1:0] mem_wdata;
    logic [POS_W-1:0] mem_raddr;

    logic [2:0]         state_reg, state_next;
    logic               boot_reg, boot_next;
    logic [POS_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [CH_W-1:0]    cur_ch_reg, cur_ch_next;
    logic [SQ_W-1:0]    cur_sq_reg, cur_sq_next;
    logic [WORK_W-1:0]  work_reg, work_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0]  root_reg, root_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               out_valid_reg, out_valid_next;
    out_t               out_reg, out_next;

    logic [SUM_W-1:0]   sum_reg [CHANNELS];
    logic [SUM_W-1:0]   sum_next [CHANNELS];
    logic [POS_W-1:0]   pos_reg [CHANNELS];
    logic [POS_W-1:0]   pos_next [CHANNELS];
    logic [COUNT_W-1:0] cnt_reg [CHANNELS];
    logic [COUNT_W-1:0] cnt_next [CHANNELS];

    logic [CH_W-1:0]    head_ch;
    logic [SQ_W-1:0]    lane_old;
    logic [ROW_W-1:0]   row_new;
    logic [SUM_W-1:0]   sum_new;
    logic [COUNT_W-1:0] thresh;
    logic [LEN_W:0]     div_trial;
    logic               div_ge;
    logic [REM_W-1:0]   sq_shift;
    logic [REM_W-1:0]   sq_trial;
    logic               sq_ge;
    logic [RMS_W-1:0]   rms_sat;
    logic               out_load;

    assign status.booting = boot_reg;
    assign empty          = ~out_valid_reg;
    assign result         = out_reg;

    // Channel of the queue head, kept in range even for an unwritten slot
    assign head_ch = (int'(q_head.ch) >= CHANNELS) ? CH_W'(CHANNELS - 1) : q_head.ch;

    assign lane_old  = row_reg[cur_ch_reg*SQ_W +: SQ_W];
    assign sum_new   = sum_reg[cur_ch_reg] - SUM_W'(lane_old) + SUM_W'(cur_sq_reg);
    assign thresh    = COUNT_W'(cfg.warmup) + COUNT_W'(cfg.len) + COUNT_W'(1);

    // One restoring division step
    assign div_trial = {rem_reg[LEN_W-1:0], work_reg[SUM_W-1]};
    assign div_ge    = (div_trial >= {1'b0, cfg.len});

    // One square root step, two operand bits at a time
    assign sq_shift  = {rem_reg[ROOT_W:0], work_reg[WORK_W-1 -: 2]};
    assign sq_trial  = {1'b0, root_reg, 2'b01};
    assign sq_ge     = (sq_shift >= sq_trial);

    assign rms_sat   = (|root_reg[ROOT_W-1:RMS_W]) ? '1 : root_reg[RMS_W-1:0];
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || pop);

    // Lane replace for the row being written back
    always_comb
    begin
        row_new = row_reg;
        row_new[cur_ch_reg*SQ_W +: SQ_W] = cur_sq_reg;
    end

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        boot_next    = boot_reg;
        clr_cnt_next = clr_cnt_reg;
        cur_ch_next  = cur_ch_reg;
        cur_sq_next  = cur_sq_reg;
        work_next    = work_reg;
        rem_next     = rem_reg;
        root_next    = root_reg;
        step_next    = step_reg;
        for (int c = 0; c < CHANNELS; c++)
        begin
            sum_next[c] = sum_reg[c];
            pos_next[c] = pos_reg[c];
            cnt_next[c] = cnt_reg[c];
        end
        q_pop     = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = clr_cnt_reg;
        mem_wdata = '0;
        mem_raddr = pos_reg[head_ch];

        unique case (state_reg)
            ST_INIT:
            begin
                // Clearing pass, one row a cycle
                mem_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == POS_W'(WINDOW_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                    boot_next  = 1'b0;
                end
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop       = 1'b1;
                    cur_ch_next = head_ch;
                    cur_sq_next = q_head.sq;
                    if (q_head.is_clear)
                    begin
                        state_next   = ST_INIT;
                        clr_cnt_next = '0;
                        for (int c = 0; c < CHANNELS; c++)
                        begin
                            sum_next[c] = '0;
                            pos_next[c] = '0;
                            cnt_next[c] = '0;
                        end
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                // Swap oldest square for the new one and advance the position
                mem_we      = 1'b1;
                mem_waddr   = pos_reg[cur_ch_reg];
                mem_wdata   = row_new;
                sum_next[cur_ch_reg] = sum_new;
                if ({1'b0, pos_reg[cur_ch_reg]} >= cfg.len - 1'b1)
                begin
                    pos_next[cur_ch_reg] = '0;
                end
                else
                begin
                    pos_next[cur_ch_reg] = pos_reg[cur_ch_reg] + 1'b1;
                end
                if (cnt_reg[cur_ch_reg] != COUNT_MAX)
                begin
                    cnt_next[cur_ch_reg] = cnt_reg[cur_ch_reg] + 1'b1;
                end
                root_next = '0;
                if (cnt_reg[cur_ch_reg] < thresh)
                begin
                    // Still warming up
                    state_next = ST_OUT;
                end
                else
                begin
                    work_next  = WORK_W'(sum_new);
                    rem_next   = '0;
                    step_next  = STEP_W'(SUM_W);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = div_ge ? REM_W'(div_trial - {1'b0, cfg.len}) : REM_W'(div_trial);
                work_next[SUM_W-1:0] = {work_reg[SUM_W-2:0], div_ge};
                step_next = step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    rem_next   = '0;
                    step_next  = STEP_W'(ROOT_W);
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                rem_next  = sq_ge ? (sq_shift - sq_trial) : sq_shift;
                root_next = {root_reg[ROOT_W-2:0], sq_ge};
                work_next = {work_reg[WORK_W-3:0], 2'b00};
                step_next = step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result register
    always_comb
    begin
        out_next = out_reg;
        if (out_load)
        begin
            out_next.rms_value   = rms_sat;
            out_next.channel_out = cur_ch_reg;
            out_valid_next       = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            boot_reg      <= 1'b1;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                sum_reg[c] <= '0;
                pos_reg[c] <= '0;
                cnt_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            boot_reg      <= boot_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            for (int c = 0; c < CHANNELS; c++)
            begin
                sum_reg[c] <= sum_next[c];
                pos_reg[c] <= pos_next[c];
                cnt_reg[c] <= cnt_next[c];
            end
        end
    end

    // Datapath registers, no reset
    always_ff @(posedge clk)
    begin
        cur_ch_reg <= cur_ch_next;
        cur_sq_reg <= cur_sq_next;
        work_reg   <= work_next;
        rem_reg    <= rem_next;
        root_reg   <= root_next;
        step_reg   <= step_next;
        out_reg    <= out_next;
    end

    // Store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        row_reg <= mem[mem_raddr];
    end

endmodule

[src/sliding_window_rms_three_channel.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_rms_three_channel
// Three-channel sliding-window RMS with a queue-style interface.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive item and raise push; the transaction is taken on a clock edge
//   with push high and full low. A clear request zeroes all channels and
//   gives no result; a sample request gives exactly one result.
//   Output: while empty is low the oldest result is on result; raise pop to
//   take it. A result waiting on a stalled receiver holds the back end at its
//   last step, while a four-entry command queue keeps accepting input.
//   Configuration: wr_en with wr_index and wr_data, only while idle.
// Sequence:
//   A sample holds the back end from dequeue to result: the dequeue step
//   with its store read, one write-back, bit-serial division by the window
//   length, two-bit-a-step square root and loading of the result register,
//   so the back end takes no new sample until the last one is through.
//   While warming up the divider and root are skipped. A clear sweeps all
//   256 rows of the store, one row a cycle through the single write port.
// Reset:
//   After reset the same clearing pass runs; full stays high until it
//   completes. Configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module sliding_window_rms_three_channel
    import swrms_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  in_t                   item,
    input  logic                  push,
    output logic                  full,
    output out_t                  result,
    output logic                  empty,
    input  logic                  pop,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data
);

    logic [LEN_W-1:0]  window_length_reg, window_length_next;
    logic [WARM_W-1:0] warmup_extra_reg, warmup_extra_next;
    cfg_t              cfg;
    back_status_t      status;
    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;
    cmd_t              q_cmd;
    cmd_t              q_head;

    // Configuration registers
    always_comb
    begin
        window_length_next = window_length_reg;
        warmup_extra_next  = warmup_extra_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_WINDOW_LENGTH: window_length_next = wr_data[LEN_W-1:0];
                CFG_WARMUP_EXTRA:  warmup_extra_next  = wr_data[WARM_W-1:0];
                default:           window_length_next = window_length_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= LEN_W'(256);
            warmup_extra_reg  <= '0;
        end
        else
        begin
            window_length_reg <= window_length_next;
            warmup_extra_reg  <= warmup_extra_next;
        end
    end

    // Effective window length: zero acts as one, capped at the store depth
    always_comb
    begin
        cfg.warmup = warmup_extra_reg;
        if (window_length_reg == '0)
        begin
            cfg.len = LEN_W'(1);
        end
        else if (int'(window_length_reg) > WINDOW_DEPTH)
        begin
            cfg.len = LEN_W'(WINDOW_DEPTH);
        end
        else
        begin
            cfg.len = window_length_reg;
        end
    end

    swrms_front u_front (
        .item   (item),
        .push   (push),
        .full   (full),
        .status (status),
        .q_full (q_full),
        .q_push (q_push),
        .q_cmd  (q_cmd)
    );

    swrms_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_cmd),
        .full  (q_full),
        .pop   (q_pop),
        .head  (q_head),
        .empty (q_empty)
    );

    swrms_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_head  (q_head),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .status  (status),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

`ifndef SYNTHESIS
    // Input is held off for the whole clearing pass after reset
    a_boot_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        status.booting |-> full)
        else $error("input accepted during reset clearing pass");

    // A transaction pushed into the queue is visible to the back end next cycle
    a_queue_holds_push: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |=> !q_empty)
        else $error("queued transaction lost");

    // Every result names a channel that exists
    a_result_channel: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (int'(result.channel_out) < CHANNELS))
        else $error("result on non-existent channel");
`endif

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the three-channel sliding-window RMS.
// A clocked driver pushes queued request transactions with random gaps, and a
// clocked monitor pops results with random stalls. Each result is checked
// against a behavioural model of the channel stores, which is updated as each
// request is accepted. Window settings change between phases while idle.
// ----------------------------------------------------------------------------
module tb;
    import swrms_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    // Worst case: a full command queue of clears plus one in flight
    localparam int SETTLE_CYCLES = 1400;
    localparam int MAX_REPORTS   = 10;

    logic                  clk;
    logic                  rst_n    = 1'b0;
    in_t                   item     = '0;
    logic                  push     = 1'b0;
    logic                  full;
    out_t                  result;
    logic                  empty;
    logic                  pop      = 1'b0;
    logic                  wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  wr_index = '0;
    logic [CFG_DATA_W-1:0] wr_data  = '0;

    sliding_window_rms_three_channel dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .push     (push),
        .full     (full),
        .result   (result),
        .empty    (empty),
        .pop      (pop),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // Model of the channel stores and the current window settings
    logic [SQ_W-1:0]   sq_hist [CHANNELS][WINDOW_DEPTH];
    longint unsigned   sq_total [CHANNELS];
    int unsigned       wpos [CHANNELS];
    int unsigned       seen [CHANNELS];
    logic [LEN_W-1:0]  cfg_len  = 9'd256;
    logic [WARM_W-1:0] cfg_warm = '0;

    in_t  pending_items [$];
    out_t rms_due [$];

    int   fail_count  = 0;
    int   cycle_count = 0;
    int   gap_left    = 0;
    int   stall_left  = 0;
    bit   calm        = 1'b0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Timeout
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Floor square root, one result bit per step from the top
    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned r;
        longint unsigned trial;
        r = 0;
        for (int b = 20; b >= 0; b--)
        begin
            trial = r | (64'd1 << b);
            if (trial * trial <= v)
                r = trial;
        end
        return r;
    endfunction

    function automatic void wipe_channels();
        for (int c = 0; c < CHANNELS; c++)
        begin
            for (int p = 0; p < WINDOW_DEPTH; p++)
                sq_hist[c][p] = '0;
            sq_total[c] = 0;
            wpos[c]     = 0;
            seen[c]     = 0;
        end
    endfunction

    // Apply one accepted request to the model and queue its expected result
    function automatic void accept_request(in_t req);
        int unsigned     ch;
        int unsigned     span;
        int unsigned     pos;
        int              s;
        longint unsigned mag;
        longint unsigned sq;
        longint unsigned root;
        out_t            res;
        if (req.req_type == REQ_CLEAR)
        begin
            wipe_channels();
            return;
        end
        // Out-of-range channel folds onto the last one
        ch = (int'(req.channel) >= CHANNELS) ? CHANNELS - 1 : 32'(req.channel);
        span = 32'(cfg_len);
        if (span == 0)
            span = 1;
        else if (span > WINDOW_DEPTH)
            span = WINDOW_DEPTH;
        s   = $signed(req.sample);
        mag = (s < 0) ? longint'(-s) : longint'(s);
        sq  = mag * mag;
        // Write at the current position even past a shortened window
        pos = wpos[ch];
        if (pos >= WINDOW_DEPTH)
            pos = 0;
        sq_total[ch]      = sq_total[ch] - 64'(sq_hist[ch][pos]) + sq;
        sq_hist[ch][pos]  = sq[SQ_W-1:0];
        pos++;
        if (pos >= span)
            pos = 0;
        wpos[ch] = pos;
        if (seen[ch] < 32'(cfg_warm) + span + 1)
            root = 0;
        else
        begin
            root = floor_root(sq_total[ch] / span);
            if (root > 65535)
                root = 65535;
        end
        if (seen[ch] < 32'(COUNT_MAX))
            seen[ch]++;
        res.rms_value   = root[RMS_W-1:0];
        res.channel_out = ch[CH_W-1:0];
        rms_due.push_back(res);
    endfunction

    function automatic void note_failure(string what);
        if (fail_count < MAX_REPORTS)
            $display("%0t: %s", $realtime, what);
        fail_count++;
    endfunction

    // Driver: one request transaction at a time, random gaps between them
    always @(posedge clk)
    begin : drive_proc
        logic taken;
        taken = push && !full;
        if (!rst_n)
        begin
            push     <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (taken)
                accept_request(item);
            if (push && !taken)
            begin
                // hold the offered transaction
            end
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                push     <= 1'b0;
            end
            else if (pending_items.size() == 0)
                push <= 1'b0;
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                gap_left <= $urandom_range(0, 4);
                push     <= 1'b0;
            end
            else
            begin
                item <= pending_items.pop_front();
                push <= 1'b1;
            end
        end
    end

    // Monitor: pops results with random stalls and checks them in order
    always @(posedge clk)
    begin : watch_proc
        out_t want;
        if (!rst_n)
        begin
            pop        <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (rms_due.size() == 0)
                    note_failure($sformatf("unexpected result: rms %0d ch %0d",
                                           result.rms_value, result.channel_out));
                else
                begin
                    want = rms_due.pop_front();
                    if (result.rms_value !== want.rms_value ||
                        result.channel_out !== want.channel_out)
                        note_failure($sformatf(
                            "mismatch: expected rms %0d ch %0d, got rms %0d ch %0d",
                            want.rms_value, want.channel_out,
                            result.rms_value, result.channel_out));
                end
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                pop        <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                stall_left <= $urandom_range(0, 4);
                pop        <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // Stimulus helpers
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        if (idx == CFG_WINDOW_LENGTH)
            cfg_len = val[LEN_W-1:0];
        else
            cfg_warm = val[WARM_W-1:0];
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    // Wait until every queued transaction is in and every result is out,
    // then let any trailing clear sweep finish
    task automatic drain();
        while (pending_items.size() != 0 || push || rms_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic void queue_sample(int ch, int value);
        in_t r;
        r.req_type = REQ_SAMPLE;
        r.channel  = ch[CH_W-1:0];
        r.sample   = value[SAMPLE_BITS-1:0];
        pending_items.push_back(r);
    endfunction

    function automatic void queue_clear();
        in_t r;
        r.req_type = REQ_CLEAR;
        r.channel  = CH_W'($urandom_range(0, 3));
        r.sample   = SAMPLE_BITS'($urandom);
        pending_items.push_back(r);
    endfunction

    // Samples biased towards the extremes and towards zero
    function automatic logic [SAMPLE_BITS-1:0] rand_sample();
        logic [SAMPLE_BITS-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = 16'h8000;
            1:       v = 16'h7FFF;
            2:       v = SAMPLE_BITS'($urandom_range(0, 3));
            3:       v = 16'hFFFF - SAMPLE_BITS'($urandom_range(0, 3));
            default: v = SAMPLE_BITS'($urandom);
        endcase
        return v;
    endfunction

    function automatic void queue_random(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < 3)
                queue_clear();
            else
                queue_sample(int'($urandom_range(0, 3)), int'(rand_sample()));
        end
    endfunction

    task automatic random_phase(input logic [CFG_DATA_W-1:0] len,
                                input logic [CFG_DATA_W-1:0] warm, input int n);
        drain();
        set_reg(CFG_WINDOW_LENGTH, len);
        set_reg(CFG_WARMUP_EXTRA, warm);
        queue_random(n);
    endtask

    // Sequence of phases
    initial
    begin
        wipe_channels();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: extremes of the sample, all still warming up
        queue_clear();
        queue_sample(0, 0);
        queue_sample(1, 32767);
        queue_sample(2, -32768);
        queue_sample(3, -1);
        queue_sample(0, 1);
        drain();

        // Window length zero acts as one; channel 3 folds onto channel 2
        set_reg(CFG_WINDOW_LENGTH, 10'd0);
        set_reg(CFG_WARMUP_EXTRA, 10'd0);
        repeat (3) queue_sample(0, -32768);
        repeat (3) queue_sample(3, 32767);
        drain();

        // Fill a short window with full-scale squares
        set_reg(CFG_WINDOW_LENGTH, 10'd4);
        queue_clear();
        repeat (6) queue_sample(1, -32768);
        drain();

        // Shrink the window below the write position: stale squares stay in
        // the sum and the root saturates; bit 9 of the data is dropped
        set_reg(CFG_WINDOW_LENGTH, 10'h201);
        repeat (2) queue_sample(1, -32768);
        queue_sample(0, -1);

        // Random phases over a range of window settings
        random_phase(10'd3, 10'd0, 60);
        random_phase(10'd1, 10'd0, 50);
        random_phase(10'd16, 10'd3, 70);
        random_phase(10'd0, 10'd1, 40);
        random_phase(CFG_DATA_W'($urandom_range(2, 40)),
                     CFG_DATA_W'($urandom_range(0, 7)), 50);

        // Longest warm-up: every result stays zero
        random_phase(10'd2, 10'd1023, 20);

        // Window above the store depth is capped at the store depth
        drain();
        set_reg(CFG_WINDOW_LENGTH, 10'd492);
        set_reg(CFG_WARMUP_EXTRA, 10'd0);
        queue_clear();
        repeat (265) queue_sample(0, rand_sample());

        // Closing phase at full rate on both sides
        drain();
        calm = 1'b1;
        set_reg(CFG_WINDOW_LENGTH, 10'd5);
        set_reg(CFG_WARMUP_EXTRA, 10'd2);
        queue_random(80);
        drain();

        if (fail_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
